/* hw/rtl/bpcw_pkg.sv */
// Shared types, sizes and codes for the BSP point contents walker.
package bpcw_pkg;

    localparam int NODES     = 8192;
    localparam int PLANES    = 8192;
    localparam int MAX_STEPS = 256;

    localparam int NODE_AW  = $clog2(NODES);
    localparam int PLANE_AW = $clog2(PLANES);
    localparam int STEP_W   = $clog2(MAX_STEPS + 1);

    localparam int IDX_W    = 13;
    localparam int NORM_W   = 18;
    localparam int COORD_W  = 24;
    localparam int CHILD_W  = 16;
    localparam int NORM_FRAC = 16;
    localparam int PROD_W   = NORM_W + COORD_W;
    localparam int SUM_W    = PROD_W + 2;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // function codes
    localparam logic [1:0] FN_PLANE = 2'd0;
    localparam logic [1:0] FN_NODE  = 2'd1;
    localparam logic [1:0] FN_POINT = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_NODE   = 2'd1;
    localparam logic [1:0] ST_STEP_LIMIT = 2'd2;

    // register indexes
    localparam logic REG_ROOT = 1'b0;
    localparam logic REG_LAST = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]          plane;
        logic signed [CHILD_W-1:0] front;
        logic signed [CHILD_W-1:0] back;
    } t_node;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } t_normal;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } t_point;

    typedef struct packed {
        logic                      node_we;
        logic                      plane_we;
        logic [IDX_W-1:0]          index;
        t_node                     node;
        t_normal                   normal;
        logic signed [COORD_W-1:0] offset;
    } t_load_wr;

    typedef struct packed {
        logic   valid;
        t_point point;
    } t_queue_rd;

    typedef struct packed {
        logic               node_re;
        logic [NODE_AW-1:0] node_addr;
        logic               plane_re;
        logic [PLANE_AW-1:0] plane_addr;
    } t_ram_rd;

endpackage

/* hw/rtl/bpcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bpcw_front.sv */
// Front end: accepts input words, performs table loads, queues point queries.
module bpcw_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_func,
    input  logic [bpcw_pkg::IDX_W-1:0]       i_index,
    input  logic signed [bpcw_pkg::NORM_W-1:0]  i_normal_x,
    input  logic signed [bpcw_pkg::NORM_W-1:0]  i_normal_y,
    input  logic signed [bpcw_pkg::NORM_W-1:0]  i_normal_z,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_plane_offset,
    input  logic [bpcw_pkg::IDX_W-1:0]       i_node_plane,
    input  logic signed [bpcw_pkg::CHILD_W-1:0] i_child_front,
    input  logic signed [bpcw_pkg::CHILD_W-1:0] i_child_back,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_point_z,
    input  logic                             i_back_busy,
    input  logic                             i_pop,
    output bpcw_pkg::t_queue_rd              o_q,
    output bpcw_pkg::t_load_wr               o_load
);
    import bpcw_pkg::*;

    t_point            r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              accept;
    logic              push;

    // loads wait until no query is queued or walking
    always_comb begin
        case (i_func) inside
            FN_PLANE, FN_NODE: o_in_ready = (r_count == '0) && !i_back_busy;
            FN_POINT:          o_in_ready = (32'(r_count) < QDEPTH);
            default:           o_in_ready = 1'b1;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;
    assign push   = accept && (i_func == FN_POINT);

    always_comb begin
        o_load.node_we  = accept && (i_func == FN_NODE) && (32'(i_index) < NODES);
        o_load.plane_we = accept && (i_func == FN_PLANE) && (32'(i_index) < PLANES);
        o_load.index    = i_index;
        o_load.node     = '{plane: i_node_plane, front: i_child_front, back: i_child_back};
        o_load.normal   = '{nx: i_normal_x, ny: i_normal_y, nz: i_normal_z};
        o_load.offset   = i_plane_offset;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{px: i_point_x, py: i_point_y, pz: i_point_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QDEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QDEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.point = r_q[r_rd_ptr];

endmodule

/* hw/rtl/bpcw_back.sv */
// Back end: walks the tree for one queued point and holds the result word.
module bpcw_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [bpcw_pkg::IDX_W-1:0]       i_root_node,
    input  logic [bpcw_pkg::IDX_W-1:0]       i_last_node,
    input  bpcw_pkg::t_queue_rd              i_q,
    output logic                             o_pop,
    output logic                             o_busy,
    output bpcw_pkg::t_ram_rd                o_rd,
    input  bpcw_pkg::t_node                  i_node,
    input  bpcw_pkg::t_normal                i_normal,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_offset,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [bpcw_pkg::CHILD_W-1:0] o_contents,
    output logic [1:0]                       o_status
);
    import bpcw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_NODE  = 3'd2;
    localparam logic [2:0] S_PLANE = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                r_state;
    logic [STEP_W-1:0]         r_steps;
    logic signed [CHILD_W-1:0] r_num;
    t_point                    r_pt;
    logic signed [CHILD_W-1:0] r_front;
    logic signed [CHILD_W-1:0] r_back;
    logic                      r_plane_ok;
    logic signed [PROD_W-1:0]  r_prod_x;
    logic signed [PROD_W-1:0]  r_prod_y;
    logic signed [PROD_W-1:0]  r_prod_z;
    logic signed [COORD_W-1:0] r_offset;
    logic signed [SUM_W-1:0]   r_sum_a;
    logic signed [SUM_W-1:0]   r_sum_b;
    logic signed [CHILD_W-1:0] r_res_contents;
    logic [1:0]                r_res_status;
    logic                      r_out_valid;
    logic signed [CHILD_W-1:0] r_out_contents;
    logic [1:0]                r_out_status;

    logic                      num_bad;
    logic signed [SUM_W-1:0]   off_ext;
    logic signed [SUM_W-1:0]   plane_dist;
    logic signed [CHILD_W-1:0] next_num;

    // r_num is never negative here
    assign num_bad = (r_num < $signed({3'b000, i_root_node}))
                  || (r_num > $signed({3'b000, i_last_node}))
                  || (32'(r_num) >= NODES);

    assign off_ext    = SUM_W'(r_offset);
    assign plane_dist = r_sum_a + r_sum_b;
    assign next_num   = plane_dist[SUM_W-1] ? r_back : r_front;

    assign o_pop  = (r_state == S_IDLE) && i_q.valid;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_rd.node_re    = (r_state == S_CHECK) && !num_bad
                       && (32'(r_steps) < MAX_STEPS);
        o_rd.node_addr  = NODE_AW'(r_num);
        o_rd.plane_re   = (r_state == S_NODE);
        o_rd.plane_addr = PLANE_AW'(i_node.plane);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_pt    <= i_q.point;
                r_num   <= $signed({3'b000, i_root_node});
                r_steps <= '0;
            end
            S_CHECK: begin
                if (num_bad) begin
                    r_res_contents <= '0;
                    r_res_status   <= ST_BAD_NODE;
                end else if (32'(r_steps) >= MAX_STEPS) begin
                    r_res_contents <= '0;
                    r_res_status   <= ST_STEP_LIMIT;
                end else begin
                    r_steps <= r_steps + 1'b1;
                end
            end
            S_NODE: begin
                r_front    <= i_node.front;
                r_back     <= i_node.back;
                r_plane_ok <= (32'(i_node.plane) < PLANES);
            end
            S_PLANE: begin
                // an out-of-table plane acts as all zero
                if (r_plane_ok) begin
                    r_prod_x <= i_normal.nx * r_pt.px;
                    r_prod_y <= i_normal.ny * r_pt.py;
                    r_prod_z <= i_normal.nz * r_pt.pz;
                    r_offset <= i_offset;
                end else begin
                    r_prod_x <= '0;
                    r_prod_y <= '0;
                    r_prod_z <= '0;
                    r_offset <= '0;
                end
            end
            S_SUM: begin
                r_sum_a <= SUM_W'(r_prod_x) + SUM_W'(r_prod_y);
                r_sum_b <= SUM_W'(r_prod_z) - (off_ext <<< NORM_FRAC);
            end
            S_DEC: begin
                r_num          <= next_num;
                r_res_contents <= next_num;
                r_res_status   <= ST_OK;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_q.valid) r_state <= S_CHECK;
                S_CHECK: begin
                    if (num_bad || (32'(r_steps) >= MAX_STEPS)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NODE;
                    end
                end
                S_NODE:  r_state <= S_PLANE;
                S_PLANE: r_state <= S_SUM;
                S_SUM:   r_state <= S_DEC;
                S_DEC:   r_state <= next_num[CHILD_W-1] ? S_OUT : S_CHECK;
                S_OUT:   if (!r_out_valid || i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_contents <= r_res_contents;
            r_out_status   <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_contents  = r_out_contents;
    assign o_status    = r_out_status;

endmodule

/* hw/rtl/bsp_point_contents_walk.sv */
// Top level of the BSP point contents walker: register port, tables, front and back.
//
// Input channel (i_in_valid / o_in_ready) takes one word per handshake.
//   func 0 writes a plane and func 1 writes a node into its table; each is
//   held off until no query is queued or walking. func 3 is dropped.
//   func 2 queues a point query (queue of two); it returns one result word.
// Output channel (o_out_valid / i_out_ready) carries contents and status.
// A query, accept to result handshake, runs the steps check, node read, plane read and
//   multiply, add, decide for each node visited, plus pop, result hand-off and output
//   register; an exit on a bad node or the step limit ends in an extra check. The walk
//   loop runs through the node and plane RAM ports. Queries walk one at a time; the
//   next pop waits until the result has gone into the output register.
// Reset clears control state and sets root_node 0, last_node 8191. Table
//   contents are not cleared and must be loaded before use; no clearing pass.
// A stalled receiver keeps the result word in the output register; the walker
//   waits with its next result, while the front keeps queueing queries.
// Registers (APB, 4-byte spacing): 0 root_node, 1 last_node. pready is tied high.
module bsp_point_contents_walk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpcw_pkg::PADDR_W-1:0]     paddr,
    input  logic [bpcw_pkg::PDATA_W-1:0]     pwdata,
    output logic [bpcw_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_func,
    input  logic [bpcw_pkg::IDX_W-1:0]       i_index,
    input  logic signed [bpcw_pkg::NORM_W-1:0]  i_normal_x,
    input  logic signed [bpcw_pkg::NORM_W-1:0]  i_normal_y,
    input  logic signed [bpcw_pkg::NORM_W-1:0]  i_normal_z,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_plane_offset,
    input  logic [bpcw_pkg::IDX_W-1:0]       i_node_plane,
    input  logic signed [bpcw_pkg::CHILD_W-1:0] i_child_front,
    input  logic signed [bpcw_pkg::CHILD_W-1:0] i_child_back,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [bpcw_pkg::COORD_W-1:0] i_point_z,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [bpcw_pkg::CHILD_W-1:0] o_contents,
    output logic [1:0]                       o_status
);
    import bpcw_pkg::*;

    logic [IDX_W-1:0]          r_root_node;
    logic [IDX_W-1:0]          r_last_node;
    logic                      reg_sel;
    logic                      cfg_wr;

    t_queue_rd                 q;
    t_load_wr                  load;
    t_ram_rd                   rd;
    logic                      pop;
    logic                      back_busy;
    logic [$bits(t_node)-1:0]  node_rdata;
    logic [$bits(t_normal)-1:0] normal_rdata;
    logic [COORD_W-1:0]        offset_rdata;

    // ---- register port ----
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_node <= '0;
            r_last_node <= '1;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ROOT: r_root_node <= pwdata[IDX_W-1:0];
                REG_LAST: r_last_node <= pwdata[IDX_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ROOT: prdata = PDATA_W'(r_root_node);
            REG_LAST: prdata = PDATA_W'(r_last_node);
            default:  prdata = '0;
        endcase
    end

    // ---- front: accept, load, queue ----
    bpcw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_index        (i_index),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_plane_offset (i_plane_offset),
        .i_node_plane   (i_node_plane),
        .i_child_front  (i_child_front),
        .i_child_back   (i_child_back),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_back_busy    (back_busy),
        .i_pop          (pop),
        .o_q            (q),
        .o_load         (load)
    );

    // ---- tables ----
    bpcw_ram #(.WIDTH($bits(t_node)), .DEPTH(NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (load.node_we),
        .i_waddr (NODE_AW'(load.index)),
        .i_wdata (load.node),
        .i_re    (rd.node_re),
        .i_raddr (rd.node_addr),
        .o_rdata (node_rdata)
    );

    bpcw_ram #(.WIDTH($bits(t_normal)), .DEPTH(PLANES)) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (load.plane_we),
        .i_waddr (PLANE_AW'(load.index)),
        .i_wdata (load.normal),
        .i_re    (rd.plane_re),
        .i_raddr (rd.plane_addr),
        .o_rdata (normal_rdata)
    );

    bpcw_ram #(.WIDTH(COORD_W), .DEPTH(PLANES)) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (load.plane_we),
        .i_waddr (PLANE_AW'(load.index)),
        .i_wdata (load.offset),
        .i_re    (rd.plane_re),
        .i_raddr (rd.plane_addr),
        .o_rdata (offset_rdata)
    );

    // ---- back: tree walk and result register ----
    bpcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_root_node (r_root_node),
        .i_last_node (r_last_node),
        .i_q         (q),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_rd        (rd),
        .i_node      (t_node'(node_rdata)),
        .i_normal    (t_normal'(normal_rdata)),
        .i_offset    ($signed(offset_rdata)),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_contents  (o_contents),
        .o_status    (o_status)
    );

`ifndef SYNTH
    // tables never change under a walk in progress
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load.node_we || load.plane_we) |-> (!back_busy && !q.valid))
        else $error("table write during a walk");

    // a clean exit always lands on a negative child
    a_ok_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |-> o_contents[CHILD_W-1])
        else $error("ok status with non-leaf contents");

    // error exits report zero contents
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_contents == '0))
        else $error("error status with nonzero contents");

    // a pop happens only with a word queued
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q.valid && !back_busy))
        else $error("pop from empty queue");
`endif

endmodule
